@@ design/glmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// glmrs_pkg
// Shared constants and types for the grid local minimum risk sum block.
// ----------------------------------------------------------------------------
package glmrs_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int HEIGHT_BITS = 4;
  localparam int ADDR_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W      = ADDR_W + 1;
  localparam int RISK_W      = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);
  localparam logic [RISK_W-1:0] RISK_MAX   = {RISK_W{1'b1}};

  // One request handed from the front to the back.
  typedef struct packed {
    logic [ADDR_W-1:0]      row;       // row of the cell to decide
    logic [ADDR_W-1:0]      col;
    logic [HEIGHT_BITS-1:0] h;         // incoming sample (down neighbor)
    logic                   ls;        // line buffer role select
    logic                   flush;     // flush item: no write, no down neighbor
    logic                   decide;    // produces a result
    logic                   has_up;
    logic                   has_right;
    logic                   last;
    logic                   clr;       // start of a new grid
  } cmd_t;

endpackage

@@ design/glmrs_ram.sv @@
// ----------------------------------------------------------------------------
// glmrs_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module glmrs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ design/glmrs_queue.sv @@
// ----------------------------------------------------------------------------
// glmrs_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module glmrs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  glmrs_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output glmrs_pkg::cmd_t head
);

  import glmrs_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ design/glmrs_front.sv @@
// ----------------------------------------------------------------------------
// glmrs_front
// Accepts items, tracks the raster position, drops out-of-place items and
// turns the rest into requests for the back.
// ----------------------------------------------------------------------------
module glmrs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic                                 action,
  input  logic [glmrs_pkg::HEIGHT_BITS-1:0]    height,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [glmrs_pkg::SIDE_W-1:0]         grid_side,
  input  logic                                 q_full,
  output logic                                 push,
  output glmrs_pkg::cmd_t                      push_cmd
);

  import glmrs_pkg::*;

  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] side_cfg;
  logic [SIDE_W-1:0] side_m1;
  logic [SIDE_W-1:0] in_row;
  logic [ADDR_W-1:0] in_col;
  logic              line_select;
  logic              in_flush;
  logic              col_last;
  logic              accept;
  logic [SIDE_W-1:0] dec_row;

  assign cfg_ready    = 1'b1;
  assign sample_stall = q_full;
  assign accept       = sample_valid && !q_full;

  always_comb begin
    if (grid_side == '0) begin
      side_cfg = SIDE_W'(1);
    end else if (grid_side > SIDE_MAX) begin
      side_cfg = SIDE_MAX;
    end else begin
      side_cfg = grid_side;
    end
  end

  assign side_m1  = side - SIDE_W'(1);
  assign in_flush = (in_row == side);
  assign col_last = ({1'b0, in_col} == side_m1);
  // Drop flush items inside the grid and samples inside the flush row.
  assign push     = accept && (in_flush == action);
  assign dec_row  = in_flush ? side_m1 : in_row - SIDE_W'(1);

  always_comb begin
    push_cmd           = '0;
    push_cmd.row       = dec_row[ADDR_W-1:0];
    push_cmd.col       = in_col;
    push_cmd.h         = height;
    push_cmd.ls        = line_select;
    push_cmd.flush     = in_flush;
    push_cmd.decide    = in_flush || (in_row != '0);
    push_cmd.has_up    = in_flush ? (side != SIDE_W'(1)) : (in_row > SIDE_W'(1));
    push_cmd.has_right = !col_last;
    push_cmd.last      = in_flush && col_last;
    push_cmd.clr       = !in_flush && (in_row == '0) && (in_col == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side        <= SIDE_RESET;
      in_row      <= '0;
      in_col      <= '0;
      line_select <= 1'b0;
    end else if (cfg_valid) begin
      side        <= side_cfg;
      in_row      <= '0;
      in_col      <= '0;
      line_select <= 1'b0;
    end else if (push) begin
      if (col_last) begin
        in_col <= '0;
        if (in_flush) begin
          in_row      <= '0;
          line_select <= 1'b0;
        end else begin
          in_row      <= in_row + SIDE_W'(1);
          line_select <= ~line_select;
        end
      end else begin
        in_col <= in_col + ADDR_W'(1);
      end
    end
  end

endmodule

@@ design/glmrs_back.sv @@
// ----------------------------------------------------------------------------
// glmrs_back
// Line buffer access, neighbor window, minimum decision and risk total.
// ----------------------------------------------------------------------------
module glmrs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_avail,
  input  glmrs_pkg::cmd_t                   q_head,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [glmrs_pkg::ADDR_W-1:0]      row,
  output logic [glmrs_pkg::ADDR_W-1:0]      col,
  output logic [glmrs_pkg::HEIGHT_BITS-1:0] cell_height,
  output logic                              is_low,
  output logic [glmrs_pkg::RISK_W-1:0]      risk_total,
  output logic                              last
);

  import glmrs_pkg::*;

  // Read stage
  cmd_t                   cmd_b;
  logic                   b_valid;
  logic                   b_fire;
  logic                   out_free;

  logic [ADDR_W-1:0]      right_addr;
  logic                   wr_up;
  logic [HEIGHT_BITS-1:0] rd0;
  logic [HEIGHT_BITS-1:0] rd1;

  // Window over the center row
  logic [HEIGHT_BITS-1:0] win_left;
  logic [HEIGHT_BITS-1:0] win_cur;
  logic [HEIGHT_BITS-1:0] first_h;

  logic [HEIGHT_BITS-1:0] cur;
  logic [HEIGHT_BITS-1:0] up_v;
  logic [HEIGHT_BITS-1:0] right_v;
  logic                   low;
  logic [RISK_W-1:0]      risk_sum;
  logic [RISK_W-1:0]      risk_next;
  logic [RISK_W:0]        risk_add;

  assign out_free = !result_valid || !result_stall;
  assign b_fire   = b_valid && (!cmd_b.decide || out_free);
  assign pop      = q_avail && (!b_valid || b_fire);

  assign right_addr = q_head.col + ADDR_W'(1);
  assign wr_up      = pop && !q_head.flush;

  // ls low: upper role in line 0, center role in line 1; ls high swaps.
  glmrs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_SIDE)) u_upper_line (
    .clk   (clk),
    .we    (wr_up && !q_head.ls),
    .waddr (q_head.col),
    .wdata (q_head.h),
    .re    (pop),
    .raddr (q_head.ls ? right_addr : q_head.col),
    .rdata (rd0)
  );

  glmrs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_SIDE)) u_center_line (
    .clk   (clk),
    .we    (wr_up && q_head.ls),
    .waddr (q_head.col),
    .wdata (q_head.h),
    .re    (pop),
    .raddr (q_head.ls ? q_head.col : right_addr),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_b <= q_head;
    end
  end

  // Decision
  assign right_v = cmd_b.ls ? rd0 : rd1;
  assign up_v    = cmd_b.ls ? rd1 : rd0;
  assign cur     = (cmd_b.col == '0) ? first_h : win_cur;

  always_comb begin
    low = 1'b1;
    if (cmd_b.has_up && !(cur < up_v)) begin
      low = 1'b0;
    end
    if (!cmd_b.flush && !(cur < cmd_b.h)) begin
      low = 1'b0;
    end
    if ((cmd_b.col != '0) && !(cur < win_left)) begin
      low = 1'b0;
    end
    if (cmd_b.has_right && !(cur < right_v)) begin
      low = 1'b0;
    end
  end

  assign risk_add = {1'b0, risk_sum} + (RISK_W + 1)'(cur) + (RISK_W + 1)'(1);

  always_comb begin
    risk_next = risk_sum;
    if (cmd_b.clr) begin
      risk_next = '0;
    end else if (cmd_b.decide && low) begin
      risk_next = risk_add[RISK_W] ? RISK_MAX : risk_add[RISK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      risk_sum <= '0;
    end else if (b_fire) begin
      risk_sum <= risk_next;
    end
  end

  // Slide the window one column.
  always_ff @(posedge clk) begin
    if (b_fire) begin
      win_left <= cur;
      win_cur  <= right_v;
      if (!cmd_b.flush && (cmd_b.col == '0)) begin
        first_h <= cmd_b.h;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_fire && cmd_b.decide) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && cmd_b.decide) begin
      row         <= cmd_b.row;
      col         <= cmd_b.col;
      cell_height <= cur;
      is_low      <= low;
      risk_total  <= risk_next;
      last        <= cmd_b.last;
    end
  end

endmodule

@@ design/grid_local_minimum_risk_sum.sv @@
// A deciding item passes the queue, the read stage register and the output register.
// Throughput: one item per cycle unless a stall holds it; the queue pop, the line
// buffer read port and the output register each pass one request per cycle.
// Reset: position, line role, side (1024) and risk total are cleared; the line
// buffers keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// grid_local_minimum_risk_sum
// Four-neighbor strict local minimum detector over a raster-order square
// grid with a saturating running risk total.
// ----------------------------------------------------------------------------
module grid_local_minimum_risk_sum (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              action,
  input  logic [glmrs_pkg::HEIGHT_BITS-1:0] height,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [glmrs_pkg::ADDR_W-1:0]      row,
  output logic [glmrs_pkg::ADDR_W-1:0]      col,
  output logic [glmrs_pkg::HEIGHT_BITS-1:0] cell_height,
  output logic                              is_low,
  output logic [glmrs_pkg::RISK_W-1:0]      risk_total,
  output logic                              last,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [glmrs_pkg::SIDE_W-1:0]      grid_side
);

  import glmrs_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_avail;
  cmd_t q_head;

  // Front: track row and column, drop misplaced items, build the request.
  // A flush item inside the grid and a sample inside the flush row are
  // accepted and dropped without touching any state.
  glmrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .action       (action),
    .height       (height),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .grid_side    (grid_side),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Short request queue: lets the front keep accepting while the back
  // waits on a stalled result.
  glmrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  // Back: each request reads the center row one column ahead and the upper
  // row at its own column; a sample request writes its sample over the upper
  // row and, past the first row, decides the cell one row above against a
  // sliding center-row window. The output register holds the result until it is taken.
  glmrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_avail      (q_avail),
    .q_head       (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row          (row),
    .col          (col),
    .cell_height  (cell_height),
    .is_low       (is_low),
    .risk_total   (risk_total),
    .last         (last)
  );

endmodule
